/* rtl/pp_pkg.sv */
// Package for the perspective projection core: register indexes, reset values
// and status codes. It has no dependencies.
package pp_pkg;

	// Every configuration register is this wide.
	localparam int REG_W = 24;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_X_OFFSET  = 2'd0;
	localparam logic [1:0] REG_Y_OFFSET  = 2'd1;
	localparam logic [1:0] REG_SCALE     = 2'd2;
	localparam logic [1:0] REG_VIEW_DIST = 2'd3;

	// Reset values: scale 1000.0 and distance 500.0 with 8 fraction bits.
	localparam logic [REG_W-1:0] SCALE_RESET     = 24'd256000;
	localparam logic [REG_W-1:0] VIEW_DIST_RESET = 24'd128000;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

endpackage

/* rtl/perspective_projection_core.sv */
// Top level of the perspective projection core: multiply, pipelined restoring
// divide, offset add, truncation and saturation. Depends on pp_pkg.
//
// Path: stages 1 and 2, the divider stages, stages 3 to 5 and the output
// register. The divider resolves one quotient bit per stage, so its depth
// sets the latency.
// Throughput: one item per cycle unless stalled; two output entries absorb a stall.
// Reset: arst_n clears all valid bits and loads the register reset values.
module perspective_projection_core
	import pp_pkg::*;
#(
	parameter int COORD_WIDTH  = 24,
	parameter int FRAC_BITS    = 8,
	parameter int SCREEN_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [REG_W-1:0]               cfg_data,
	// Input channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [COORD_WIDTH-1:0]  point_x,
	input  logic signed [COORD_WIDTH-1:0]  point_y,
	input  logic signed [COORD_WIDTH-1:0]  point_z,
	// Output channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SCREEN_WIDTH-1:0] screen_x,
	output logic signed [SCREEN_WIDTH-1:0] screen_y,
	output logic [1:0]                     status
);

	// Product, magnitude, denominator and quotient widths.
	localparam int PW   = COORD_WIDTH + REG_W;
	localparam int NW   = PW - 1;
	localparam int MW   = (COORD_WIDTH > REG_W) ? COORD_WIDTH : REG_W;
	localparam int QW   = NW + 1;
	localparam int SWD  = QW + 1;
	localparam int POSW = SWD - FRAC_BITS;

	localparam logic [SWD-1:0] RND_ADD =
		SWD'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic signed [POSW-1:0] POS_HI =
		POSW'((64'd1 << (SCREEN_WIDTH - 1)) - 64'd1);
	localparam logic signed [POSW-1:0] POS_LO = -POS_HI - POSW'(1);

	// Configuration registers.
	logic [REG_W-1:0] x_off_q, y_off_q, scale_q, vdist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q <= '0;
			y_off_q <= '0;
			scale_q <= SCALE_RESET;
			vdist_q <= VIEW_DIST_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_OFFSET:  x_off_q <= cfg_data;
				REG_Y_OFFSET:  y_off_q <= cfg_data;
				REG_SCALE:     scale_q <= cfg_data;
				REG_VIEW_DIST: vdist_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline advances unless the output buffer is full.
	logic skid_valid_q;
	logic en;
	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// Stage 1: products and denominator.
	logic                  vld_s1;
	logic signed [PW-1:0]  prod_x_s1, prod_y_s1;
	logic signed [MW:0]    den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= point_x * $signed({1'b0, scale_q});
			prod_y_s1 <= point_y * $signed({1'b0, scale_q});
			den_s1    <= {{(MW + 1 - COORD_WIDTH){point_z[COORD_WIDTH-1]}}, point_z}
				+ {{(MW + 1 - REG_W){vdist_q[REG_W-1]}}, vdist_q};
		end
	end

	// Divider stage arrays; index 0 holds the magnitudes and signs.
	logic          vld_sd  [0:NW];
	logic          zero_sd [0:NW];
	logic          negx_sd [0:NW];
	logic          negy_sd [0:NW];
	logic [MW:0]   dmag_sd [0:NW];
	logic [NW-1:0] numx_sd [0:NW];
	logic [NW-1:0] numy_sd [0:NW];
	logic [MW:0]   remx_sd [0:NW];
	logic [MW:0]   remy_sd [0:NW];

	// Stage 2: magnitudes, quotient signs and the zero denominator flag.
	logic [PW-1:0] absx, absy;
	logic [MW:0]   absd;
	assign absx = prod_x_s1[PW-1] ? PW'(-prod_x_s1) : PW'(prod_x_s1);
	assign absy = prod_y_s1[PW-1] ? PW'(-prod_y_s1) : PW'(prod_y_s1);
	assign absd = den_s1[MW] ? (MW+1)'(-den_s1) : (MW+1)'(den_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sd[0] <= 1'b0;
		else if (en) vld_sd[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_sd[0] <= (den_s1 == '0);
			negx_sd[0] <= prod_x_s1[PW-1] ^ den_s1[MW];
			negy_sd[0] <= prod_y_s1[PW-1] ^ den_s1[MW];
			dmag_sd[0] <= absd;
			numx_sd[0] <= absx[NW-1:0];
			numy_sd[0] <= absy[NW-1:0];
			remx_sd[0] <= '0;
			remy_sd[0] <= '0;
		end
	end

	// Restoring divider: one quotient bit per stage for each axis. The
	// numerator shifts out at the top while quotient bits enter at the bottom.
	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [MW+1:0] shx, shy, trx, try_d;
		assign shx   = {remx_sd[k], numx_sd[k][NW-1]};
		assign shy   = {remy_sd[k], numy_sd[k][NW-1]};
		assign trx   = shx - {1'b0, dmag_sd[k]};
		assign try_d = shy - {1'b0, dmag_sd[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sd[k+1] <= 1'b0;
			else if (en) vld_sd[k+1] <= vld_sd[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_sd[k+1] <= zero_sd[k];
				negx_sd[k+1] <= negx_sd[k];
				negy_sd[k+1] <= negy_sd[k];
				dmag_sd[k+1] <= dmag_sd[k];
				remx_sd[k+1] <= trx[MW+1] ? shx[MW:0] : trx[MW:0];
				remy_sd[k+1] <= try_d[MW+1] ? shy[MW:0] : try_d[MW:0];
				numx_sd[k+1] <= {numx_sd[k][NW-2:0], !trx[MW+1]};
				numy_sd[k+1] <= {numy_sd[k][NW-2:0], !try_d[MW+1]};
			end
		end
	end

	// Stage 3: signed quotients.
	logic                 vld_s3, zero_s3;
	logic signed [QW-1:0] qx_s3, qy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_sd[NW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3 <= zero_sd[NW];
			qx_s3   <= negx_sd[NW] ? -$signed({1'b0, numx_sd[NW]})
				: $signed({1'b0, numx_sd[NW]});
			qy_s3   <= negy_sd[NW] ? -$signed({1'b0, numy_sd[NW]})
				: $signed({1'b0, numy_sd[NW]});
		end
	end

	// Stage 4: add the screen offsets.
	logic                  vld_s4, zero_s4;
	logic signed [SWD-1:0] sx_s4, sy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= zero_s3;
			sx_s4   <= {qx_s3[QW-1], qx_s3}
				+ {{(SWD - REG_W){x_off_q[REG_W-1]}}, x_off_q};
			sy_s4   <= {qy_s3[QW-1], qy_s3}
				+ {{(SWD - REG_W){y_off_q[REG_W-1]}}, y_off_q};
		end
	end

	// Stage 5: drop the fraction toward zero, clamp to the screen range, set status.
	logic [SWD-1:0]         adjx, adjy;
	logic signed [POSW-1:0] posx, posy;
	logic                   hix, lox, hiy, loy;
	logic [SCREEN_WIDTH-1:0] satx, saty;

	assign adjx = sx_s4[SWD-1] ? SWD'(sx_s4 + RND_ADD) : sx_s4;
	assign adjy = sy_s4[SWD-1] ? SWD'(sy_s4 + RND_ADD) : sy_s4;
	assign posx = $signed(adjx[SWD-1:FRAC_BITS]);
	assign posy = $signed(adjy[SWD-1:FRAC_BITS]);
	assign hix  = posx > POS_HI;
	assign lox  = posx < POS_LO;
	assign hiy  = posy > POS_HI;
	assign loy  = posy < POS_LO;

	always_comb begin
		satx = posx[SCREEN_WIDTH-1:0];
		saty = posy[SCREEN_WIDTH-1:0];
		if (hix) satx = POS_HI[SCREEN_WIDTH-1:0];
		if (lox) satx = POS_LO[SCREEN_WIDTH-1:0];
		if (hiy) saty = POS_HI[SCREEN_WIDTH-1:0];
		if (loy) saty = POS_LO[SCREEN_WIDTH-1:0];
	end

	logic                    vld_s5;
	logic [SCREEN_WIDTH-1:0] scrx_s5, scry_s5;
	logic [1:0]              stat_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s4) begin
				scrx_s5 <= '0;
				scry_s5 <= '0;
				stat_s5 <= ST_ZERO;
			end else begin
				scrx_s5 <= satx;
				scry_s5 <= saty;
				stat_s5 <= (hix || lox || hiy || loy) ? ST_SAT : ST_OK;
			end
		end
	end

	// Output register with a skid entry behind it.
	logic                    out_valid_q;
	logic [SCREEN_WIDTH-1:0] outx_q, outy_q, skx_q, sky_q;
	logic [1:0]              outst_q, skst_q;
	logic                    take, arrive;

	assign take   = out_valid_q && !out_stall;
	assign arrive = en && vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q <= arrive;
		end else if (arrive) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				outx_q  <= skx_q;
				outy_q  <= sky_q;
				outst_q <= skst_q;
			end
		end else if (!out_valid_q || take) begin
			outx_q  <= scrx_s5;
			outy_q  <= scry_s5;
			outst_q <= stat_s5;
		end else begin
			skx_q  <= scrx_s5;
			sky_q  <= scry_s5;
			skst_q <= stat_s5;
		end
	end

	assign out_valid = out_valid_q;
	assign screen_x  = $signed(outx_q);
	assign screen_y  = $signed(outy_q);
	assign status    = outst_q;

	// The skid entry is only ever filled behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds an item with no result in front");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid entry filled while the output was free");

	a_zero_gives_zeros: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_ZERO) |-> (screen_x == '0 && screen_y == '0))
		else $error("zero denominator result carries nonzero positions");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_ZERO))
		else $error("undefined status code on a valid result");

endmodule
